// File: rtl/core/modular_exponentiation_defines.svh
// assertion macros for the modular exponentiation block
// used by the top level only, no other dependencies
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MEXP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp assertion failed");

// next-cycle implication, disabled while reset is high
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp assertion failed");

`endif

// File: rtl/core/mexp_pkg.sv
// shared widths and types for the modular exponentiation block
// no dependencies; used by mexp_modmul and modular_exponentiation
package mexp_pkg;

   localparam int WIDTH = 16;              // operand width
   localparam int MOD_W = WIDTH + 1;       // modulus, zero register means 2^WIDTH
   localparam int SUM_W = WIDTH + 2;       // 2r + y stays below 3m
   localparam int CNT_W = $clog2(WIDTH);   // multiplier bit counter

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// File: rtl/core/modular_exponentiation.sv
// modular exponentiation, right-to-left square-and-multiply over one shared multiplier
// sequence: a zero exponent goes straight to the result, else the base is reduced first, then each
// exponent bit costs a multiply if set and a square (one bit a cycle in mexp_modmul)
// throughput: one transaction at a time, the next accepted once the result is staged
// reset: synchronous active high; modulus resets to 1, sequencer idle, no result pending
// depends on mexp_pkg, mexp_modmul and modular_exponentiation_defines.svh
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*mexp_pkg::WIDTH-1:0]      req_tdata,   // exponent (high), base_value (low)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mexp_pkg::WIDTH-1:0]        rsp_tdata,   // power_result
   input  logic                              csr_wr_en,
   input  logic [mexp_pkg::WIDTH-1:0]        csr_wr_data  // modulus
);
   import mexp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_MUL,
      S_SQR,
      S_DONE
   } state_type;

   state_type        state_ff;
   logic [WIDTH-1:0] mod_ff;
   logic [WIDTH-1:0] base_ff;
   logic [WIDTH-1:0] exp_ff;
   logic [WIDTH-1:0] acc_ff;
   logic             start_ff;
   logic             rsp_valid_ff;
   logic [WIDTH-1:0] rsp_data_ff;

   logic [MOD_W-1:0] mod_eff;
   logic [WIDTH-1:0] mul_x;
   logic [WIDTH-1:0] mul_y;
   logic [WIDTH-1:0] product;
   mul_stat_type     mul_stat;
   logic [WIDTH-1:0] exp_in;
   logic             out_free;
   logic             mul_phase;
   logic             done_acc_high;

   // a zero register wraps at the operand width
   assign mod_eff  = {mod_ff == '0, mod_ff};
   assign exp_in   = exp_ff >> 1;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign mul_phase     = (state_ff == S_REDUCE) || (state_ff == S_MUL) || (state_ff == S_SQR);
   assign done_acc_high = (state_ff == S_DONE) && (MOD_W'(acc_ff) >= mod_eff);

   always_comb begin
      case (state_ff)
         S_REDUCE: begin
            mul_x = base_ff;
            mul_y = WIDTH'(1);
         end
         S_MUL: begin
            mul_x = acc_ff;
            mul_y = base_ff;
         end
         default: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
      endcase
   end

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .op_mod  (mod_eff),
      .product (product),
      .stat    (mul_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= WIDTH'(1);
      end else if (csr_wr_en) begin
         mod_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  base_ff <= req_tdata[WIDTH-1:0];
                  exp_ff  <= req_tdata[2*WIDTH-1:WIDTH];
                  acc_ff  <= WIDTH'(1);
                  if (req_tdata[2*WIDTH-1:WIDTH] == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_REDUCE;
                     start_ff <= 1'b1;
                  end
               end
            end
            S_REDUCE: begin
               if (mul_stat.done) begin
                  base_ff  <= product;
                  state_ff <= exp_ff[0] ? S_MUL : S_SQR;
                  start_ff <= 1'b1;
               end
            end
            S_MUL: begin
               if (mul_stat.done) begin
                  acc_ff   <= product;
                  state_ff <= S_SQR;
                  start_ff <= 1'b1;
               end
            end
            S_SQR: begin
               if (mul_stat.done) begin
                  base_ff <= product;
                  exp_ff  <= exp_in;
                  if (exp_in == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= exp_in[0] ? S_MUL : S_SQR;
                     start_ff <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= acc_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the shared multiplier only finishes while a multiply state waits on it
   `MEXP_ASSERT_IMP(a_done_in_mul_state, clock, reset, mul_stat.done, mul_phase)
   // no new transaction while the multiplier is running
   `MEXP_ASSERT_IMP(a_idle_mul_free, clock, reset, req_tready, !mul_stat.busy && !start_ff)
   // a finished accumulator is below the modulus unless it was never multiplied
   `MEXP_ASSERT_IMP(a_acc_reduced, clock, reset, done_acc_high, acc_ff == WIDTH'(1))
   // every multiply launch is followed by the unit going busy
   `MEXP_ASSERT_NEXT(a_start_busy, clock, reset, start_ff, mul_stat.busy)

endmodule

// File: rtl/core/mexp_modmul.sv
// interleaved shift-add modular multiplier, one multiplier bit per cycle
// computes (x * y) mod m for y <= m; depends on mexp_pkg
module mexp_modmul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mexp_pkg::WIDTH-1:0]  op_x,
   input  logic [mexp_pkg::WIDTH-1:0]  op_y,
   input  logic [mexp_pkg::MOD_W-1:0]  op_mod,
   output logic [mexp_pkg::WIDTH-1:0]  product,
   output mexp_pkg::mul_stat_type      stat
);
   import mexp_pkg::*;

   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] x_ff;
   logic [WIDTH-1:0] y_ff;
   logic [MOD_W-1:0] m_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] m1;
   logic [SUM_W-1:0] m2;

   // r <- (2r + x_i*y) mod m, with r < m and y <= m at most two subtractions
   always_comb begin
      sum = {1'b0, r_ff, 1'b0} + (x_ff[WIDTH-1] ? SUM_W'(y_ff) : '0);
      m1  = SUM_W'(m_ff);
      m2  = {m_ff, 1'b0};
      if (sum >= m2) begin
         r_in = WIDTH'(sum - m2);
      end else if (sum >= m1) begin
         r_in = WIDTH'(sum - m1);
      end else begin
         r_in = WIDTH'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(WIDTH - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff <= '0;
         x_ff <= op_x;
         y_ff <= op_y;
         m_ff <= op_mod;
      end else if (busy_ff) begin
         r_ff <= r_in;
         x_ff <= {x_ff[WIDTH-2:0], 1'b0};
      end
   end

   assign product   = r_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
